### design/mlasm_pkg.sv
package mlasm_pkg;

  localparam int PTR_W  = 6;
  localparam int IDX_W  = 10;
  localparam int ITEM_W = 32;
  localparam int CFG_W  = 11;
  localparam int CNT_W  = 7;

  typedef enum logic [1:0] {
    ACT_APPEND = 2'd0,
    ACT_DUMP   = 2'd1,
    ACT_SPLICE = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_APPEND_LINK,
    ST_SPLICE_LINK,
    ST_SPLICE_CLR,
    ST_DUMP_HEAD,
    ST_WALK,
    ST_BAD_OUT
  } state_t;

  typedef struct packed {
    logic             nonempty;
    logic [PTR_W-1:0] head;
    logic [PTR_W-1:0] tail;
  } list_entry_t;

endpackage

### design/mlasm_list_ram.sv
module mlasm_list_ram #(
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                   clk,
  input  logic                   we,
  input  logic [AW-1:0]          waddr,
  input  mlasm_pkg::list_entry_t wdata,
  input  logic                   re,
  input  logic [AW-1:0]          raddr_a,
  input  logic [AW-1:0]          raddr_b,
  output mlasm_pkg::list_entry_t rdata_a,
  output mlasm_pkg::list_entry_t rdata_b
);

  mlasm_pkg::list_entry_t mem [DEPTH];
  mlasm_pkg::list_entry_t rdata_a_r;
  mlasm_pkg::list_entry_t rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a_r <= mem[raddr_a];
      rdata_b_r <= mem[raddr_b];
    end
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

### design/mlasm_node_ram.sv
module mlasm_node_ram #(
  parameter int DEPTH = 64,
  parameter int VW = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        we_full,
  input  logic                        we_next,
  input  logic [AW-1:0]               waddr,
  input  logic [VW-1:0]               wval,
  input  logic [mlasm_pkg::PTR_W-1:0] wnxt,
  input  logic                        re,
  input  logic [AW-1:0]               raddr,
  output logic [VW-1:0]               rval,
  output logic [mlasm_pkg::PTR_W-1:0] rnxt
);

  logic [VW-1:0]               val_mem [DEPTH];
  logic [mlasm_pkg::PTR_W-1:0] nxt_mem [DEPTH];
  logic [VW-1:0]               rval_r;
  logic [mlasm_pkg::PTR_W-1:0] rnxt_r;

  // a link update rewrites only the next pointer of an entry
  always_ff @(posedge clk) begin
    if (we_full) begin
      val_mem[waddr] <= wval;
    end
    if (we_full || we_next) begin
      nxt_mem[waddr] <= wnxt;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rval_r <= val_mem[raddr];
      rnxt_r <= nxt_mem[raddr];
    end
  end

  assign rval = rval_r;
  assign rnxt = rnxt_r;

endmodule

### design/multi_list_append_splice_manager_core.sv
// append: ST_APPEND_LINK; splice: ST_SPLICE_LINK, then ST_SPLICE_CLR unless the source is empty
// dump: first result via the list table read, node memory read and output register (an empty list
//   or bad index result from ST_DUMP_HEAD or ST_BAD_OUT), then one per cycle from the node memory
//   read port, pausing while the output register is stalled; one request at a time, the next taken
//   once the last result is loaded (other requests: once back in ST_IDLE); reset: synchronous, then
//   a clear of all LIST_COUNT list table entries taking no request; configuration writes taken throughout
module multi_list_append_splice_manager_core #(
  parameter int LIST_COUNT = 1024,
  parameter int NODE_COUNT = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [mlasm_pkg::CFG_W-1:0]         cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          in_action,
  input  logic [mlasm_pkg::IDX_W-1:0]         in_first_list,
  input  logic [mlasm_pkg::IDX_W-1:0]         in_second_list,
  input  logic signed [mlasm_pkg::ITEM_W-1:0] in_item_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [mlasm_pkg::ITEM_W-1:0] out_element_value,
  output logic                                out_list_empty,
  output logic                                out_bad_index,
  output logic                                out_last_of_dump
);

  localparam int PTR_W = mlasm_pkg::PTR_W;
  localparam int CNT_W = mlasm_pkg::CNT_W;
  localparam int OUT_W = mlasm_pkg::ITEM_W;
  localparam int AW = $clog2(LIST_COUNT);
  localparam int XW = (AW > mlasm_pkg::IDX_W) ? AW : mlasm_pkg::IDX_W;
  localparam int NW = $clog2(NODE_COUNT);
  localparam int LCW = $clog2(LIST_COUNT + 1);
  localparam int LUW = (LCW > mlasm_pkg::CFG_W) ? LCW : mlasm_pkg::CFG_W;
  localparam int EVW = (VALUE_WIDTH > OUT_W) ? VALUE_WIDTH : OUT_W;

  mlasm_pkg::state_t state_r, state_nxt;
  logic [AW-1:0]     clr_r, clr_nxt;
  logic [CNT_W-1:0]  nodes_used_r, nodes_used_nxt;
  logic [LUW-1:0]    liu_r, liu_nxt;
  logic [AW-1:0]     a_addr_r, a_addr_nxt;
  logic [AW-1:0]     b_addr_r, b_addr_nxt;
  logic [PTR_W-1:0]  n_r, n_nxt;
  logic [PTR_W-1:0]  p_r, p_nxt;
  logic [PTR_W-1:0]  tail_r, tail_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]  out_val_r;
  logic              out_empty_r, out_bad_r, out_last_r;

  // list table port signals
  logic                   lr_re;
  logic                   lw_we;
  logic [AW-1:0]          lw_addr;
  mlasm_pkg::list_entry_t lw_data;
  mlasm_pkg::list_entry_t ra, rb;

  // node memory port signals
  logic                   nw_full, nw_next;
  logic [NW-1:0]          nw_addr;
  logic [PTR_W-1:0]       nw_nxt;
  logic                   nr_re;
  logic [NW-1:0]          nr_addr;
  logic [VALUE_WIDTH-1:0] node_rval;
  logic [PTR_W-1:0]       node_rnxt;

  logic [XW-1:0]          a_x, b_x;
  logic [AW-1:0]          a_addr_in, b_addr_in;
  logic                   a_ok, b_ok, pool_full, slot_free;
  logic [EVW-1:0]         in_ext, node_ext;
  logic [VALUE_WIDTH-1:0] in_val;
  logic                   p_in_range, walk_last;
  logic [OUT_W-1:0]       walk_val;
  logic                   out_load;
  logic [OUT_W-1:0]       o_val;
  logic                   o_empty, o_bad, o_last;

  assign a_x = XW'(in_first_list);
  assign b_x = XW'(in_second_list);
  assign a_addr_in = a_x[AW-1:0];
  assign b_addr_in = b_x[AW-1:0];
  assign a_ok = (32'(in_first_list) < 32'(liu_r)) && (32'(in_first_list) < 32'(LIST_COUNT));
  assign b_ok = (32'(in_second_list) < 32'(liu_r))
             && (32'(in_second_list) < 32'(LIST_COUNT));
  assign pool_full = nodes_used_r >= CNT_W'(NODE_COUNT);
  assign slot_free = !out_valid_r || !out_stall;

  // stored values keep the low bits of the sign-extended request value
  assign in_ext = EVW'(in_item_value);
  assign in_val = in_ext[VALUE_WIDTH-1:0];

  assign p_in_range = 32'(p_r) < 32'(NODE_COUNT);
  assign walk_last = (p_r == tail_r) || ((cnt_r + CNT_W'(1)) >= CNT_W'(NODE_COUNT))
                  || !p_in_range;
  assign node_ext = EVW'($signed(node_rval));
  assign walk_val = p_in_range ? node_ext[OUT_W-1:0] : '0;

  mlasm_list_ram #(
    .DEPTH(LIST_COUNT)
  ) u_list_ram (
    .clk     (clk),
    .we      (lw_we),
    .waddr   (lw_addr),
    .wdata   (lw_data),
    .re      (lr_re),
    .raddr_a (a_addr_in),
    .raddr_b (b_addr_in),
    .rdata_a (ra),
    .rdata_b (rb)
  );

  mlasm_node_ram #(
    .DEPTH(NODE_COUNT),
    .VW   (VALUE_WIDTH)
  ) u_node_ram (
    .clk     (clk),
    .we_full (nw_full),
    .we_next (nw_next),
    .waddr   (nw_addr),
    .wval    (in_val),
    .wnxt    (nw_nxt),
    .re      (nr_re),
    .raddr   (nr_addr),
    .rval    (node_rval),
    .rnxt    (node_rnxt)
  );

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    nodes_used_nxt = nodes_used_r;
    liu_nxt        = cfg_we ? LUW'(cfg_wdata) : liu_r;
    a_addr_nxt     = a_addr_r;
    b_addr_nxt     = b_addr_r;
    n_nxt          = n_r;
    p_nxt          = p_r;
    tail_nxt       = tail_r;
    cnt_nxt        = cnt_r;
    lr_re          = 1'b0;
    lw_we          = 1'b0;
    lw_addr        = a_addr_r;
    lw_data        = '0;
    nw_full        = 1'b0;
    nw_next        = 1'b0;
    nw_addr        = nodes_used_r[NW-1:0];
    nw_nxt         = '0;
    nr_re          = 1'b0;
    nr_addr        = node_rnxt[NW-1:0];
    out_load       = 1'b0;
    o_val          = '0;
    o_empty        = 1'b0;
    o_bad          = 1'b0;
    o_last         = 1'b0;
    case (state_r)
      mlasm_pkg::ST_CLEAR: begin
        lw_we   = 1'b1;
        lw_addr = clr_r;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(LIST_COUNT - 1)) begin
          state_nxt = mlasm_pkg::ST_IDLE;
        end
      end
      mlasm_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (mlasm_pkg::action_t'(in_action))
            mlasm_pkg::ACT_APPEND: begin
              if (a_ok && !pool_full) begin
                nw_full        = 1'b1;
                lr_re          = 1'b1;
                a_addr_nxt     = a_addr_in;
                n_nxt          = nodes_used_r[PTR_W-1:0];
                nodes_used_nxt = nodes_used_r + CNT_W'(1);
                state_nxt      = mlasm_pkg::ST_APPEND_LINK;
              end
            end
            mlasm_pkg::ACT_DUMP: begin
              if (!a_ok) begin
                state_nxt = mlasm_pkg::ST_BAD_OUT;
              end else begin
                lr_re     = 1'b1;
                state_nxt = mlasm_pkg::ST_DUMP_HEAD;
              end
            end
            mlasm_pkg::ACT_SPLICE: begin
              if (a_ok && b_ok && (in_first_list != in_second_list)) begin
                lr_re      = 1'b1;
                a_addr_nxt = a_addr_in;
                b_addr_nxt = b_addr_in;
                state_nxt  = mlasm_pkg::ST_SPLICE_LINK;
              end
            end
            default: ;
          endcase
        end
      end
      mlasm_pkg::ST_APPEND_LINK: begin
        lw_we            = 1'b1;
        lw_addr          = a_addr_r;
        lw_data.nonempty = 1'b1;
        lw_data.head     = ra.nonempty ? ra.head : n_r;
        lw_data.tail     = n_r;
        if (ra.nonempty && (32'(ra.tail) < 32'(NODE_COUNT))) begin
          nw_next = 1'b1;
          nw_addr = ra.tail[NW-1:0];
          nw_nxt  = n_r;
        end
        state_nxt = mlasm_pkg::ST_IDLE;
      end
      mlasm_pkg::ST_SPLICE_LINK: begin
        if (!ra.nonempty) begin
          state_nxt = mlasm_pkg::ST_IDLE;
        end else begin
          lw_we            = 1'b1;
          lw_addr          = b_addr_r;
          lw_data.nonempty = 1'b1;
          lw_data.head     = rb.nonempty ? rb.head : ra.head;
          lw_data.tail     = ra.tail;
          if (rb.nonempty && (32'(rb.tail) < 32'(NODE_COUNT))) begin
            nw_next = 1'b1;
            nw_addr = rb.tail[NW-1:0];
            nw_nxt  = ra.head;
          end
          state_nxt = mlasm_pkg::ST_SPLICE_CLR;
        end
      end
      mlasm_pkg::ST_SPLICE_CLR: begin
        // source goes empty, its pointers are left as they were
        lw_we            = 1'b1;
        lw_addr          = a_addr_r;
        lw_data.nonempty = 1'b0;
        lw_data.head     = ra.head;
        lw_data.tail     = ra.tail;
        state_nxt        = mlasm_pkg::ST_IDLE;
      end
      mlasm_pkg::ST_DUMP_HEAD: begin
        if (!ra.nonempty) begin
          if (slot_free) begin
            out_load  = 1'b1;
            o_empty   = 1'b1;
            o_last    = 1'b1;
            state_nxt = mlasm_pkg::ST_IDLE;
          end
        end else begin
          nr_re     = 1'b1;
          nr_addr   = ra.head[NW-1:0];
          p_nxt     = ra.head;
          tail_nxt  = ra.tail;
          cnt_nxt   = '0;
          state_nxt = mlasm_pkg::ST_WALK;
        end
      end
      mlasm_pkg::ST_WALK: begin
        // node data for p_r sits in the read register; fetch the next one as it leaves
        if (slot_free) begin
          out_load = 1'b1;
          o_val    = walk_val;
          o_last   = walk_last;
          if (walk_last) begin
            state_nxt = mlasm_pkg::ST_IDLE;
          end else begin
            nr_re   = 1'b1;
            nr_addr = node_rnxt[NW-1:0];
            p_nxt   = node_rnxt;
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
      end
      mlasm_pkg::ST_BAD_OUT: begin
        if (slot_free) begin
          out_load  = 1'b1;
          o_bad     = 1'b1;
          o_last    = 1'b1;
          state_nxt = mlasm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mlasm_pkg::ST_IDLE;
      end
    endcase
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= mlasm_pkg::ST_CLEAR;
      clr_r        <= '0;
      nodes_used_r <= '0;
      liu_r        <= LUW'(LIST_COUNT);
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      nodes_used_r <= nodes_used_nxt;
      liu_r        <= liu_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_addr_r <= a_addr_nxt;
    b_addr_r <= b_addr_nxt;
    n_r      <= n_nxt;
    p_r      <= p_nxt;
    tail_r   <= tail_nxt;
    cnt_r    <= cnt_nxt;
    if (out_load) begin
      out_val_r   <= o_val;
      out_empty_r <= o_empty;
      out_bad_r   <= o_bad;
      out_last_r  <= o_last;
    end
  end

  assign in_stall          = (state_r != mlasm_pkg::ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_element_value = out_val_r;
  assign out_list_empty    = out_empty_r;
  assign out_bad_index     = out_bad_r;
  assign out_last_of_dump  = out_last_r;

endmodule

### design/mlasm_checker.sv
module mlasm_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                cfg_we,
  input logic [mlasm_pkg::CFG_W-1:0]         cfg_wdata,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic [1:0]                          in_action,
  input logic [mlasm_pkg::IDX_W-1:0]         in_first_list,
  input logic [mlasm_pkg::IDX_W-1:0]         in_second_list,
  input logic signed [mlasm_pkg::ITEM_W-1:0] in_item_value,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [mlasm_pkg::ITEM_W-1:0] out_element_value,
  input logic                                out_list_empty,
  input logic                                out_bad_index,
  input logic                                out_last_of_dump
);

  // list table clearing runs right after reset
  a_clear_after_reset: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("request taken during list table clearing");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_element_value)
      && $stable(out_list_empty) && $stable(out_bad_index) && $stable(out_last_of_dump))
    else $error("stalled result changed");

  // empty and bad index results are single, zero valued and exclusive
  a_special_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_list_empty || out_bad_index) |->
      out_last_of_dump && (out_element_value == '0) && !(out_list_empty && out_bad_index))
    else $error("malformed empty or bad index result");

  // a dump always produces a result, so the block is busy right after taking one
  a_dump_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_action == mlasm_pkg::ACT_DUMP) |=> in_stall)
    else $error("dump request finished without a result");

endmodule

bind multi_list_append_splice_manager_core mlasm_checker u_mlasm_checker (.*);

### tb/multi_list_append_splice_manager_core_tb.sv
module multi_list_append_splice_manager_core_tb;

  localparam int ITEM_W = mlasm_pkg::ITEM_W;
  localparam int CFG_W  = mlasm_pkg::CFG_W;
  localparam int IDX_W  = mlasm_pkg::IDX_W;
  localparam int PTR_W  = mlasm_pkg::PTR_W;
  localparam logic [1:0] ACT_APPEND = mlasm_pkg::ACT_APPEND;
  localparam logic [1:0] ACT_DUMP   = mlasm_pkg::ACT_DUMP;
  localparam logic [1:0] ACT_SPLICE = mlasm_pkg::ACT_SPLICE;

  localparam int LISTS = 1024;
  localparam int NODES = 64;
  localparam int CYCLE_LIMIT = 5_000_000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_REQUESTS = 76;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef struct packed {
    logic signed [ITEM_W-1:0] value;
    logic                     list_empty;
    logic                     bad_index;
    logic                     last_beat;
  } dump_beat_t;

  typedef struct packed {
    logic               is_cfg;
    logic [CFG_W-1:0]   cfg_val;
    logic [1:0]         act;
    logic [IDX_W-1:0]   list_a;
    logic [IDX_W-1:0]   list_b;
    logic [ITEM_W-1:0]  item;
    logic               typed;
    dump_beat_t         want;
  } step_t;

  localparam dump_beat_t NO_BEAT    = '0;
  localparam dump_beat_t EMPTY_DUMP = '{32'sd0, 1'b1, 1'b0, 1'b1};
  localparam dump_beat_t BAD_DUMP   = '{32'sd0, 1'b0, 1'b1, 1'b1};

  localparam int PLAN_LEN = 27;
  localparam step_t PLAN [PLAN_LEN] = '{
    '{1'b1, 11'd1024, ACT_APPEND, 10'd0,    10'd0,    32'h0000_0000, 1'b0, NO_BEAT},
    '{1'b0, 11'd0,    ACT_DUMP,   10'd1023, 10'd0,    32'h0000_0000, 1'b1, EMPTY_DUMP},
    '{1'b0, 11'd0,    ACT_DUMP,   10'd0,    10'd1023, 32'hFFFF_FFFF, 1'b1, EMPTY_DUMP},
    '{1'b0, 11'd0,    ACT_APPEND, 10'd0,    10'd1023, 32'h7FFF_FFFF, 1'b0, NO_BEAT},
    '{1'b0, 11'd0,    ACT_APPEND, 10'd0,    10'd0,    32'h8000_0000, 1'b0, NO_BEAT},
    '{1'b0, 11'd0,    ACT_APPEND, 10'd1023, 10'd0,    32'hFFFF_FFFF, 1'b0, NO_BEAT},
    '{1'b0, 11'd0,    ACT_APPEND, 10'd1023, 10'd0,    32'h0000_0000, 1'b0, NO_BEAT},
    '{1'b0, 11'd0,    ACT_APPEND, 10'd0,    10'd0,    32'h5A5A_A5A5, 1'b0, NO_BEAT},
    '{1'b0, 11'd0,    ACT_DUMP,   10'd0,    10'd0,    32'h0000_0000, 1'b0, NO_BEAT},
    '{1'b0, 11'd0,    ACT_DUMP,   10'd1023, 10'd0,    32'h0000_0000, 1'b0, NO_BEAT},
    '{1'b0, 11'd0,    ACT_SPLICE, 10'd0,    10'd1023, 32'h0000_0000, 1'b0, NO_BEAT},
    // empty source and self splice change nothing
    '{1'b0, 11'd0,    ACT_SPLICE, 10'd5,    10'd1023, 32'h0000_0000, 1'b0, NO_BEAT},
    '{1'b0, 11'd0,    ACT_SPLICE, 10'd1023, 10'd1023, 32'h0000_0000, 1'b0, NO_BEAT},
    '{1'b0, 11'd0,    ACT_DUMP,   10'd0,    10'd0,    32'h0000_0000, 1'b1, EMPTY_DUMP},
    '{1'b0, 11'd0,    ACT_DUMP,   10'd1023, 10'd0,    32'h0000_0000, 1'b0, NO_BEAT},
    '{1'b0, 11'd0,    ACT_UNUSED, 10'd1023, 10'd1023, 32'hFFFF_FFFF, 1'b0, NO_BEAT},
    '{1'b0, 11'd0,    ACT_APPEND, 10'd2,    10'd0,    32'h0000_0001, 1'b0, NO_BEAT},
    '{1'b0, 11'd0,    ACT_SPLICE, 10'd1023, 10'd2,    32'h0000_0000, 1'b0, NO_BEAT},
    '{1'b0, 11'd0,    ACT_DUMP,   10'd2,    10'd0,    32'h0000_0000, 1'b0, NO_BEAT},
    '{1'b1, 11'd3,    ACT_APPEND, 10'd0,    10'd0,    32'h0000_0000, 1'b0, NO_BEAT},
    '{1'b0, 11'd0,    ACT_DUMP,   10'd3,    10'd0,    32'h0000_0000, 1'b1, BAD_DUMP},
    '{1'b0, 11'd0,    ACT_DUMP,   10'd1023, 10'd0,    32'h0000_0000, 1'b1, BAD_DUMP},
    '{1'b0, 11'd0,    ACT_APPEND, 10'd3,    10'd0,    32'h1234_5678, 1'b0, NO_BEAT},
    '{1'b0, 11'd0,    ACT_SPLICE, 10'd2,    10'd900,  32'h0000_0000, 1'b0, NO_BEAT},
    '{1'b0, 11'd0,    ACT_SPLICE, 10'd1000, 10'd0,    32'h0000_0000, 1'b0, NO_BEAT},
    '{1'b0, 11'd0,    ACT_DUMP,   10'd2,    10'd0,    32'h0000_0000, 1'b0, NO_BEAT},
    '{1'b0, 11'd0,    ACT_DUMP,   10'd1,    10'd0,    32'h0000_0000, 1'b1, EMPTY_DUMP}
  };

  localparam int PHASES = 5;
  localparam logic [CFG_W-1:0] PHASE_LIMITS [PHASES] = '{11'd1024, 11'd6, 11'd1, 11'd300, 11'd1024};

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_we = 1'b0;
  logic [CFG_W-1:0]         cfg_wdata = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [1:0]               in_action = '0;
  logic [IDX_W-1:0]         in_first_list = '0;
  logic [IDX_W-1:0]         in_second_list = '0;
  logic signed [ITEM_W-1:0] in_item_value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [ITEM_W-1:0] out_element_value;
  logic                     out_list_empty;
  logic                     out_bad_index;
  logic                     out_last_of_dump;

  // shadow copy of the list tables and node pool
  logic [PTR_W-1:0]  list_head [LISTS];
  logic [PTR_W-1:0]  list_tail [LISTS];
  bit                list_filled [LISTS];
  logic [ITEM_W-1:0] pool_value [NODES];
  logic [PTR_W-1:0]  pool_next [NODES];
  int                pool_used = 0;
  int                live_lists = LISTS;

  dump_beat_t dump_beats_due [$];

  bit idle_on = 1'b1;
  int stall_left = 0;
  int cycle_count = 0;
  int errors = 0;
  int requests_sent = 0;
  int beats_checked = 0;
  int longest_dump = 0;

  multi_list_append_splice_manager_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_first_list     (in_first_list),
    .in_second_list    (in_second_list),
    .in_item_value     (in_item_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_element_value (out_element_value),
    .out_list_empty    (out_list_empty),
    .out_bad_index     (out_bad_index),
    .out_last_of_dump  (out_last_of_dump)
  );

  always #5 clk = ~clk;

  function automatic bit list_valid(input logic [IDX_W-1:0] idx);
    return int'(idx) < live_lists;
  endfunction

  function automatic void add_due_beat(input dump_beat_t beat);
    dump_beats_due.insert(dump_beats_due.size(), beat);
  endfunction

  // applies one accepted request to the shadow lists; returns 1 if it did anything
  function automatic bit advance_lists(input logic [1:0] act, input logic [IDX_W-1:0] a,
                                       input logic [IDX_W-1:0] b, input logic [ITEM_W-1:0] v);
    logic [PTR_W-1:0] p;
    int count;
    dump_beat_t beat;
    case (act)
      ACT_APPEND: begin
        if (!list_valid(a) || pool_used >= NODES) return 1'b0;
        pool_value[pool_used] = v;
        pool_next[pool_used] = '0;
        if (list_filled[a]) begin
          pool_next[list_tail[a]] = pool_used[PTR_W-1:0];
        end else begin
          list_head[a] = pool_used[PTR_W-1:0];
          list_filled[a] = 1'b1;
        end
        list_tail[a] = pool_used[PTR_W-1:0];
        pool_used++;
        return 1'b1;
      end
      ACT_DUMP: begin
        if (!list_valid(a)) begin
          add_due_beat(BAD_DUMP);
          return 1'b1;
        end
        if (!list_filled[a]) begin
          add_due_beat(EMPTY_DUMP);
          return 1'b1;
        end
        p = list_head[a];
        count = 0;
        do begin
          beat.value = pool_value[p];
          beat.list_empty = 1'b0;
          beat.bad_index = 1'b0;
          beat.last_beat = (p == list_tail[a]) || (count + 1 >= NODES);
          add_due_beat(beat);
          count++;
          p = pool_next[p];
        end while (!beat.last_beat);
        if (count > longest_dump) longest_dump = count;
        return 1'b1;
      end
      ACT_SPLICE: begin
        if (!list_valid(a) || !list_valid(b) || a == b || !list_filled[a]) return 1'b0;
        if (list_filled[b]) begin
          pool_next[list_tail[b]] = list_head[a];
        end else begin
          list_head[b] = list_head[a];
          list_filled[b] = 1'b1;
        end
        list_tail[b] = list_tail[a];
        list_filled[a] = 1'b0;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic int pick_gap();
    int k;
    if (!idle_on) return 0;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  // mostly a handful of hot lists so that chains get long
  function automatic logic [IDX_W-1:0] pick_list();
    int k;
    k = $urandom_range(0, 99);
    if (k < 70) return IDX_W'($urandom_range(0, 7));
    if (k < 80) return IDX_W'(1023 - $urandom_range(0, 3));
    return IDX_W'($urandom_range(0, 1023));
  endfunction

  task automatic send_request(input logic [1:0] act, input logic [IDX_W-1:0] a,
                              input logic [IDX_W-1:0] b, input logic [ITEM_W-1:0] v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_first_list <= a;
    in_second_list <= b;
    in_item_value <= v;
    do @(posedge clk); while (in_stall !== 1'b0);
    requests_sent++;
  endtask

  // wait for every pending dump result, then for append/splice to finish
  task automatic settle();
    in_valid <= 1'b0;
    while (dump_beats_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_lists_in_use(input logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    live_lists = int'(val);
  endtask

  task automatic report_mismatch(input string what, input logic [ITEM_W-1:0] got,
                                 input logic [ITEM_W-1:0] want);
    $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      out_stall <= 1'b1;
      stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(8, 25) : $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : check_results
    dump_beat_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (dump_beats_due.size() == 0) begin
        report_mismatch("result with no dump pending", out_element_value, '0);
      end else begin
        want = dump_beats_due.pop_front();
        if (out_element_value !== want.value)
          report_mismatch("element_value", out_element_value, want.value);
        if (out_list_empty !== want.list_empty)
          report_mismatch("list_empty", 32'(out_list_empty), 32'(want.list_empty));
        if (out_bad_index !== want.bad_index)
          report_mismatch("bad_index", 32'(out_bad_index), 32'(want.bad_index));
        if (out_last_of_dump !== want.last_beat)
          report_mismatch("last_of_dump", 32'(out_last_of_dump), 32'(want.last_beat));
        beats_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending", cycle_count,
               dump_beats_due.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : stimulus
    int done_here;
    int r;
    int append_pct;
    logic [1:0] act;
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
    logic [ITEM_W-1:0] v;

    for (int i = 0; i < LISTS; i++) list_filled[i] = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < PLAN_LEN; i++) begin
      if (PLAN[i].is_cfg) begin
        settle();
        write_lists_in_use(PLAN[i].cfg_val);
      end else begin
        send_request(PLAN[i].act, PLAN[i].list_a, PLAN[i].list_b, PLAN[i].item);
        if (PLAN[i].typed) add_due_beat(PLAN[i].want);
        else void'(advance_lists(PLAN[i].act, PLAN[i].list_a, PLAN[i].list_b, PLAN[i].item));
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      write_lists_in_use(PHASE_LIMITS[ph]);
      idle_on = (ph != 3);
      done_here = 0;
      while (done_here < PHASE_REQUESTS) begin
        append_pct = (pool_used < NODES) ? 45 : 5;
        r = $urandom_range(0, 99);
        if (r < append_pct) act = ACT_APPEND;
        else if (r < append_pct + 4) act = ACT_UNUSED;
        else if (r < append_pct + 34) act = ACT_SPLICE;
        else act = ACT_DUMP;
        a = pick_list();
        b = pick_list();
        v = $urandom;
        send_request(act, a, b, v);
        void'(advance_lists(act, a, b, v));
        done_here++;
      end
    end

    // fill the pool, gather every list onto list 0 and dump the full chain
    while (pool_used < NODES) begin
      a = IDX_W'($urandom_range(0, 7));
      v = $urandom;
      send_request(ACT_APPEND, a, '0, v);
      void'(advance_lists(ACT_APPEND, a, '0, v));
    end
    for (int i = 1; i < LISTS; i++) begin
      if (list_filled[i]) begin
        send_request(ACT_SPLICE, IDX_W'(i), '0, '0);
        void'(advance_lists(ACT_SPLICE, IDX_W'(i), '0, '0));
      end
    end
    send_request(ACT_DUMP, '0, '0, '0);
    void'(advance_lists(ACT_DUMP, '0, '0, '0));

    settle();
    $display("sent %0d requests, checked %0d dump results, longest dump %0d elements",
             requests_sent, beats_checked, longest_dump);
    $display("lists_in_use stepped through 1024, 3, 1024, 6, 1, 300, 1024; pool filled %0d of %0d",
             pool_used, NODES);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
